// ===== design/gce_pkg.sv =====
package gce_pkg;

  // Fixed field widths
  localparam int OP_W   = 3;
  localparam int ITER_W = 6;
  localparam int IO_W   = 32;

  localparam logic [ITER_W-1:0] ITER_RESET = ITER_W'(16);

  // Default datapath sizing
  localparam int DATA_WIDTH_DEF     = 32;
  localparam int FRAC_BITS_DEF      = 16;
  localparam int MAX_ITERATIONS_DEF = 32;

  // Coordinate system codes, taken from operation[2:1]
  localparam logic [1:0] SYS_CIRCULAR   = 2'd0;
  localparam logic [1:0] SYS_LINEAR     = 2'd1;
  localparam logic [1:0] SYS_HYPERBOLIC = 2'd2;
  localparam logic [1:0] SYS_INVALID    = 2'd3;

  // Mode code, taken from operation[0]
  localparam logic MODE_VECTORING = 1'b1;

  // Restoring division, used only while building the step tables
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [64:0] rem;
    logic [63:0] quo;
    rem = '0;
    quo = '0;
    for (int b = 63; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem    = rem - {1'b0, den};
        quo[b] = 1'b1;
      end
    end
    return quo;
  endfunction

  // Odd power series of 1/n with 62 fraction bits, alternating for atan
  function automatic logic [63:0] series(input logic [63:0] n, input logic alt);
    logic [63:0] p;
    logic [63:0] sum;
    logic [63:0] term;
    p   = udiv64(64'h4000_0000_0000_0000, n);
    sum = '0;
    for (int k = 0; k < 64; k++) begin
      if (p != '0) begin
        term = udiv64(p, 64'(2 * k + 1));
        if (alt && k[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
        p = udiv64(udiv64(p, n), n);
      end
    end
    return sum;
  endfunction

  // Round a 62-fraction-bit value half up to frac fraction bits
  function automatic logic [63:0] to_frac(input logic [63:0] q, input int frac);
    int s;
    s = (frac >= 62) ? 0 : 62 - frac;
    if (s == 0) begin
      return q;
    end
    return (q + (64'd1 << (s - 1))) >> s;
  endfunction

  // Angle step e(i) for one coordinate system
  function automatic logic [63:0] step_angle(input logic [1:0] sys, input int i,
                                             input int frac);
    logic [63:0] q;
    if (i > 62) begin
      return '0;
    end
    if (sys == SYS_CIRCULAR) begin
      q = (i == 0) ? 64'd4 * series(64'd5, 1'b1) - series(64'd239, 1'b1)
                   : series(64'd1 << i, 1'b1);
    end else if (sys == SYS_LINEAR) begin
      q = 64'd1 << (62 - i);
    end else begin
      q = (i == 0) ? '0 : series(64'd1 << i, 1'b0);
    end
    return to_frac(q, frac);
  endfunction

  // Hyperbolic shift index of micro-rotation k (4, 13 and 40 run twice)
  function automatic int hyp_index(input int k);
    int  idx;
    logic rep;
    idx = 1;
    rep = 1'b0;
    for (int j = 0; j < 64; j++) begin
      if (j < k) begin
        if (!rep && (idx == 4 || idx == 13 || idx == 40)) begin
          rep = 1'b1;
        end else begin
          idx = idx + 1;
          rep = 1'b0;
        end
      end
    end
    return idx;
  endfunction

endpackage

// ===== design/generalized_cordic_engine_core.sv =====
// Pipeline: one input register, then one register stage per unrolled micro-rotation.
// Throughput: one vector per cycle while out_tready holds; stages carry no feedback.
// Stalls fill empty stages first: while results wait, requests enter until all are full.
// Reset (rst_n low, synchronous) empties every stage and sets iteration_count to 16.
module generalized_cordic_engine_core #(
  parameter int DATA_WIDTH     = gce_pkg::DATA_WIDTH_DEF,
  parameter int FRAC_BITS      = gce_pkg::FRAC_BITS_DEF,
  parameter int MAX_ITERATIONS = gce_pkg::MAX_ITERATIONS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Configuration: iteration_count
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gce_pkg::ITER_W-1:0]    cfg_data,
  // Input requests
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [3*gce_pkg::IO_W-1:0]    in_tdata,  // x_in, y_in, z_in
  input  logic [gce_pkg::OP_W-1:0]      in_tuser,  // operation
  // Results
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [3*gce_pkg::IO_W-1:0]    out_tdata  // x_out, y_out, z_out
);
  import gce_pkg::*;

  localparam int LAST = MAX_ITERATIONS;

  logic [ITER_W-1:0] cnt_r;

  // Stage registers: stage 0 holds the input, stage k+1 the result of rotation k
  logic [LAST:0]                 v_r;
  logic [OP_W-1:0]               op_r [0:LAST];
  logic signed [DATA_WIDTH-1:0]  x_r  [0:LAST];
  logic signed [DATA_WIDTH-1:0]  y_r  [0:LAST];
  logic signed [DATA_WIDTH-1:0]  z_r  [0:LAST];

  logic signed [DATA_WIDTH-1:0]  x_nxt [0:LAST];
  logic signed [DATA_WIDTH-1:0]  y_nxt [0:LAST];
  logic signed [DATA_WIDTH-1:0]  z_nxt [0:LAST];
  logic [OP_W-1:0]               op_nxt [0:LAST];
  logic [LAST:0]                 vin;
  logic [LAST:0]                 rdy;

  // Configuration register, always writable
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= ITER_RESET;
    end else if (cfg_valid) begin
      cnt_r <= cfg_data;
    end
  end

  // Input stage: sign-extend or wrap each coordinate into the datapath width
  assign vin[0]    = in_tvalid;
  assign op_nxt[0] = in_tuser;
  assign x_nxt[0]  = DATA_WIDTH'(signed'(in_tdata[IO_W-1:0]));
  assign y_nxt[0]  = DATA_WIDTH'(signed'(in_tdata[2*IO_W-1:IO_W]));
  assign z_nxt[0]  = DATA_WIDTH'(signed'(in_tdata[3*IO_W-1:2*IO_W]));

  // Ready chain: a stage loads when it is empty or its content moves on
  assign rdy[LAST] = !v_r[LAST] || out_tready;
  assign in_tready = rdy[0];

  genvar gk;
  generate
    for (gk = 0; gk < LAST; gk++) begin : g_rot
      localparam int HI = hyp_index(gk);
      localparam logic [63:0] E_CIRC = step_angle(SYS_CIRCULAR, gk, FRAC_BITS);
      localparam logic [63:0] E_LIN  = step_angle(SYS_LINEAR, gk, FRAC_BITS);
      localparam logic [63:0] E_HYP  = step_angle(SYS_HYPERBOLIC, HI, FRAC_BITS);

      logic [1:0]                   sys;
      logic                         active;
      logic                         pos;
      logic signed [DATA_WIDTH-1:0] sx;
      logic signed [DATA_WIDTH-1:0] sy;
      logic signed [DATA_WIDTH-1:0] e;

      assign rdy[gk]        = !v_r[gk] || rdy[gk+1];
      assign vin[gk+1]      = v_r[gk];
      assign op_nxt[gk+1]   = op_r[gk];
      assign sys            = op_r[gk][2:1];
      assign active         = (sys != SYS_INVALID) && (cnt_r > ITER_W'(gk));

      // Steer by sign of y when vectoring, sign of z when rotating
      assign pos = (op_r[gk][0] == MODE_VECTORING) ? y_r[gk][DATA_WIDTH-1]
                                                   : !z_r[gk][DATA_WIDTH-1];

      // Shifted cross terms and angle step of this micro-rotation
      always_comb begin
        if (sys == SYS_HYPERBOLIC) begin
          sx = x_r[gk] >>> HI;
          sy = y_r[gk] >>> HI;
        end else begin
          sx = x_r[gk] >>> gk;
          sy = y_r[gk] >>> gk;
        end
        unique case (sys)
          SYS_CIRCULAR:   e = E_CIRC[DATA_WIDTH-1:0];
          SYS_LINEAR:     e = E_LIN[DATA_WIDTH-1:0];
          SYS_HYPERBOLIC: e = E_HYP[DATA_WIDTH-1:0];
          default:        e = '0;
        endcase
      end

      // Apply the rotation, or pass the vector through when inactive
      always_comb begin
        x_nxt[gk+1] = x_r[gk];
        y_nxt[gk+1] = y_r[gk];
        z_nxt[gk+1] = z_r[gk];
        if (active) begin
          unique case (sys)
            SYS_CIRCULAR:   x_nxt[gk+1] = pos ? x_r[gk] - sy : x_r[gk] + sy;
            SYS_HYPERBOLIC: x_nxt[gk+1] = pos ? x_r[gk] + sy : x_r[gk] - sy;
            default:        x_nxt[gk+1] = x_r[gk];
          endcase
          y_nxt[gk+1] = pos ? y_r[gk] + sx : y_r[gk] - sx;
          z_nxt[gk+1] = pos ? z_r[gk] - e : z_r[gk] + e;
        end
      end
    end
  endgenerate

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      for (int k = 0; k <= LAST; k++) begin
        if (rdy[k]) begin
          v_r[k] <= vin[k];
        end
      end
    end
  end

  // Advance payload, hold on stall
  always_ff @(posedge clk) begin
    for (int k = 0; k <= LAST; k++) begin
      if (rdy[k] && vin[k]) begin
        op_r[k] <= op_nxt[k];
        x_r[k]  <= x_nxt[k];
        y_r[k]  <= y_nxt[k];
        z_r[k]  <= z_nxt[k];
      end
    end
  end

  // Result: low 32 bits, sign-extended when the datapath is narrower
  assign out_tvalid = v_r[LAST];
  assign out_tdata  = {IO_W'(z_r[LAST]), IO_W'(y_r[LAST]), IO_W'(x_r[LAST])};

  // A free output never stalls the input side
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_tready |-> in_tready)
    else $error("input stalled while output is free");

  // Reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result present right after reset");

  generate
    for (gk = 0; gk < LAST; gk++) begin : g_chk
      // Linear system never changes x
      a_linear_x: assert property (@(posedge clk) disable iff (!rst_n)
        v_r[gk] && rdy[gk+1] && (op_r[gk][2:1] == SYS_LINEAR)
        |=> x_r[gk+1] == $past(x_r[gk]))
        else $error("linear stage changed x");

      // Invalid operation passes the vector through
      a_invalid_pass: assert property (@(posedge clk) disable iff (!rst_n)
        v_r[gk] && rdy[gk+1] && (op_r[gk][2:1] == SYS_INVALID)
        |=> (x_r[gk+1] == $past(x_r[gk])) && (y_r[gk+1] == $past(y_r[gk]))
            && (z_r[gk+1] == $past(z_r[gk])))
        else $error("invalid operation altered the vector");
    end
  endgenerate

endmodule

// ===== tb/sv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gce_pkg::*;

  localparam int LATENCY     = MAX_ITERATIONS_DEF + 1;
  localparam int DIR_ROWS    = 20;
  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 140;

  typedef enum logic [OP_W-1:0] {
    OP_CIRC_ROT = 3'd0,
    OP_CIRC_VEC = 3'd1,
    OP_LIN_ROT  = 3'd2,
    OP_LIN_VEC  = 3'd3,
    OP_HYP_ROT  = 3'd4,
    OP_HYP_VEC  = 3'd5,
    OP_BAD_6    = 3'd6,
    OP_BAD_7    = 3'd7
  } op_t;

  typedef struct packed {
    op_t               op;
    logic [IO_W-1:0]   x;
    logic [IO_W-1:0]   y;
    logic [IO_W-1:0]   z;
  } vec_t;

  // Packed to match out_tdata: z in the top bits, x in the bottom bits
  typedef struct packed {
    logic [IO_W-1:0] z;
    logic [IO_W-1:0] y;
    logic [IO_W-1:0] x;
  } res_t;

  typedef struct packed {
    op_t             op;
    logic [IO_W-1:0] x;
    logic [IO_W-1:0] y;
    logic [IO_W-1:0] z;
    bit              known;
    logic [IO_W-1:0] ex;
    logic [IO_W-1:0] ey;
    logic [IO_W-1:0] ez;
  } dir_row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [ITER_W-1:0]      cfg_data = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [3*IO_W-1:0]      in_tdata = '0;   // x_in, y_in, z_in
  logic [OP_W-1:0]        in_tuser = '0;   // operation
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [3*IO_W-1:0]      out_tdata;       // x_out, y_out, z_out

  logic [ITER_W-1:0]      iter_count;
  logic signed [IO_W-1:0] angle_step [3][64];
  res_t                   expected_vectors [$];
  int                     mismatch_count = 0;
  int                     src_idle_pct = 11;
  int                     snk_idle_pct = 76;

  // Directed vectors at the reset iteration count; invalid operations pass through
  dir_row_t dir_rows [DIR_ROWS] = '{
    '{OP_CIRC_ROT, 32'h0000_9B75, 32'h0000_0000, 32'h0000_C910, 1'b0, '0, '0, '0},
    '{OP_CIRC_ROT, 32'h0001_0000, 32'h0000_0000, 32'hFFFF_36F0, 1'b0, '0, '0, '0},
    '{OP_CIRC_VEC, 32'h0001_0000, 32'h0001_0000, 32'h0000_0000, 1'b0, '0, '0, '0},
    '{OP_CIRC_VEC, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, '0, '0, '0},
    '{OP_CIRC_ROT, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 1'b0, '0, '0, '0},
    '{OP_CIRC_ROT, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0, '0, '0},
    '{OP_LIN_ROT,  32'h0002_0000, 32'h0000_0000, 32'h0001_8000, 1'b0, '0, '0, '0},
    '{OP_LIN_VEC,  32'h0002_0000, 32'h0003_0000, 32'h0000_0000, 1'b0, '0, '0, '0},
    '{OP_LIN_ROT,  32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0, '0, '0},
    '{OP_LIN_VEC,  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0, '0, '0, '0},
    '{OP_HYP_ROT,  32'h0001_0000, 32'h0000_0000, 32'h0000_8000, 1'b0, '0, '0, '0},
    '{OP_HYP_VEC,  32'h0002_0000, 32'h0001_0000, 32'h0000_0000, 1'b0, '0, '0, '0},
    '{OP_HYP_ROT,  32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0, '0, '0},
    '{OP_HYP_VEC,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, '0, '0, '0},
    '{OP_CIRC_VEC, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, '0, '0, '0},
    '{OP_HYP_ROT,  32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 1'b0, '0, '0, '0},
    '{OP_LIN_ROT,  32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1'b0, '0, '0, '0},
    '{OP_BAD_6, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
      1'b1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF},
    '{OP_BAD_7, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
      1'b1, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000},
    '{OP_BAD_7, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F,
      1'b1, 32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F}
  };

  generalized_cordic_engine_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Odd power series of 1/n in Q62, alternating signs give atan, plain signs atanh
  function automatic longint unsigned odd_power_sum(longint unsigned n, bit alternate);
    longint unsigned p;
    longint unsigned acc;
    longint unsigned term;
    longint unsigned k;
    p = (64'd1 << 62) / n;
    acc = 0;
    k = 0;
    while (p != 0) begin
      term = p / (2 * k + 1);
      if (alternate && k[0]) acc = acc - term;
      else acc = acc + term;
      p = p / n / n;
      k++;
    end
    return acc;
  endfunction

  // Fill the per-system angle steps, rounded half up to 16 fraction bits
  function automatic void build_angle_steps();
    longint unsigned q;
    for (int s = 0; s < 3; s++) begin
      for (int i = 0; i < 64; i++) begin
        if (i > 62) begin
          q = 0;
        end else if (s == SYS_CIRCULAR) begin
          q = (i == 0) ? 4 * odd_power_sum(5, 1'b1) - odd_power_sum(239, 1'b1)
                       : odd_power_sum(64'd1 << i, 1'b1);
        end else if (s == SYS_LINEAR) begin
          q = 64'd1 << (62 - i);
        end else begin
          q = (i == 0) ? 64'd0 : odd_power_sum(64'd1 << i, 1'b0);
        end
        q = (q + (64'd1 << (61 - FRAC_BITS_DEF))) >> (62 - FRAC_BITS_DEF);
        angle_step[s][i] = q[IO_W-1:0];
      end
    end
  endfunction

  // Run the micro-rotations for one vector at the current iteration count
  function automatic res_t cordic_predict(vec_t v);
    logic [OP_W-1:0]        opc;
    logic [1:0]             sys;
    logic                   vectoring;
    logic signed [IO_W-1:0] x, y, z, sx, sy, nx;
    int                     n, idx;
    bit                     repeated, d_pos;
    res_t                   r;
    opc = v.op;
    sys = opc[2:1];
    vectoring = (opc[0] == MODE_VECTORING);
    x = v.x;
    y = v.y;
    z = v.z;
    if (sys != SYS_INVALID) begin
      n = (iter_count > MAX_ITERATIONS_DEF) ? MAX_ITERATIONS_DEF : int'(iter_count);
      idx = (sys == SYS_HYPERBOLIC) ? 1 : 0;
      repeated = 1'b0;
      for (int k = 0; k < n; k++) begin
        d_pos = vectoring ? y[IO_W-1] : !z[IO_W-1];
        sx = x >>> idx;
        sy = y >>> idx;
        nx = x;
        if (sys == SYS_CIRCULAR) nx = d_pos ? x - sy : x + sy;
        else if (sys == SYS_HYPERBOLIC) nx = d_pos ? x + sy : x - sy;
        y = d_pos ? y + sx : y - sx;
        z = d_pos ? z - angle_step[sys][idx] : z + angle_step[sys][idx];
        x = nx;
        // Hyperbolic indices 4, 13 and 40 run twice
        if (sys == SYS_HYPERBOLIC && !repeated && (idx == 4 || idx == 13 || idx == 40)) begin
          repeated = 1'b1;
        end else begin
          idx++;
          repeated = 1'b0;
        end
      end
    end
    r.x = x;
    r.y = y;
    r.z = z;
    return r;
  endfunction

  // Pick a coordinate: full range, a few units of fixed point, or an extreme
  function automatic logic [IO_W-1:0] random_coord();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) return $urandom();
    if (pick < 85) return $urandom_range(32'h0008_0000) - 32'h0004_0000;
    case ($urandom_range(4))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return 32'h0000_0001;
    endcase
  endfunction

  function automatic vec_t random_vector();
    vec_t v;
    v.op = ($urandom_range(99) < 92) ? op_t'($urandom_range(OP_HYP_VEC))
                                     : op_t'($urandom_range(OP_BAD_7));
    v.x = random_coord();
    v.y = random_coord();
    v.z = random_coord();
    return v;
  endfunction

  // Offer one request after a random gap, queue its result once it is taken
  task automatic send_vector(vec_t v, res_t want);
    @(negedge clk);
    while ($urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= v.op;
    in_tdata  <= {v.z, v.y, v.x};
    do @(posedge clk); while (!in_tready);
    expected_vectors.push_back(want);
  endtask

  // Hold off requests until every queued result has come back
  task automatic drain_results();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_vectors.size() != 0) @(posedge clk);
  endtask

  // Write the iteration count once the pipeline is empty
  task automatic write_iter_count(logic [ITER_W-1:0] value);
    drain_results();
    repeat (LATENCY) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    iter_count = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Randomize result backpressure
  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= snk_idle_pct);
  end

  // Compare each result with the oldest queued expectation
  always @(posedge clk) begin
    res_t want;
    res_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata;
      if (expected_vectors.size() == 0) begin
        $error("result with nothing expected: x=%h y=%h z=%h", got.x, got.y, got.z);
        mismatch_count++;
      end else begin
        want = expected_vectors.pop_front();
        if (got.x !== want.x) begin
          $error("x_out mismatch: expected %h, got %h", want.x, got.x);
          mismatch_count++;
        end
        if (got.y !== want.y) begin
          $error("y_out mismatch: expected %h, got %h", want.y, got.y);
          mismatch_count++;
        end
        if (got.z !== want.z) begin
          $error("z_out mismatch: expected %h, got %h", want.z, got.z);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    #2_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [ITER_W-1:0] phase_counts [PHASES];
    vec_t              v;
    res_t              want;
    build_angle_steps();
    iter_count = ITER_RESET;
    phase_counts = '{6'd1, 6'd32, 6'd63, 6'd0, 6'd5, 6'd0};
    phase_counts[PHASES-1] = ITER_W'($urandom_range(2, 31));

    // Hold reset, then release it
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Walk the directed table
    foreach (dir_rows[r]) begin
      v.op = dir_rows[r].op;
      v.x  = dir_rows[r].x;
      v.y  = dir_rows[r].y;
      v.z  = dir_rows[r].z;
      if (dir_rows[r].known) begin
        want.x = dir_rows[r].ex;
        want.y = dir_rows[r].ey;
        want.z = dir_rows[r].ez;
      end else begin
        want = cordic_predict(v);
      end
      send_vector(v, want);
    end

    // Random phases, each writing its iteration count; the idle pattern changes at phases 2 and 4
    for (int p = 0; p < PHASES; p++) begin
      write_iter_count(phase_counts[p]);
      if (p >= 4) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end else if (p >= 2) begin
        src_idle_pct = 76;
        snk_idle_pct = 11;
      end
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (p == 2 && n == PHASE_ITEMS / 2) drain_results();
        v = random_vector();
        send_vector(v, cordic_predict(v));
      end
    end

    // Let the pipeline empty, then watch for stray results
    drain_results();
    repeat (LATENCY + 8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
